[rtl/rtpt_pkg.sv]
// shared types and constants of the rx timing peak tracker
package rtpt_pkg;

    localparam int RTPT_HALF_WINDOW  = 256;
    localparam int RTPT_MAX_ANTENNAS = 4;

    localparam int SAMPLE_W = 16;
    localparam int POS_W    = 9;
    localparam int ACC_W    = 33;
    localparam int HSQ_W    = 30;
    localparam int PWR_W    = 31;
    localparam int COEF_W   = 15;
    localparam int HYST_W   = 8;
    localparam int FRAME_W  = 8;
    localparam int CNT_W    = 4;

    localparam logic [COEF_W-1:0] COEF_FULL    = 15'd32767;
    localparam logic [CNT_W-1:0]  STABLE_MAX   = 4'd15;
    localparam logic [CNT_W-1:0]  LOCK_COUNT   = 4'd10;
    localparam logic [POS_W-1:0]  STABLE_LIMIT = 9'd5;
    localparam logic [POS_W-1:0]  HIGH_BAND_ADD = 9'd2;

    // configuration register indexes
    localparam logic [2:0] REG_FILTER_COEF = 3'd0;
    localparam logic [2:0] REG_HYSTERESIS  = 3'd1;
    localparam logic [2:0] REG_HIGH_BAND   = 3'd2;
    localparam logic [2:0] REG_SIDELINK    = 3'd3;
    localparam logic [2:0] REG_RANDOM_ACC  = 3'd4;

    typedef struct packed {
        logic [PWR_W-1:0]        power;
        logic signed [POS_W-1:0] tap;
        logic                    last_ant;
        logic                    last_tap;
        logic                    clear;
        logic [FRAME_W-1:0]      frame;
    } t_sample;

    typedef struct packed {
        logic [ACC_W-1:0]        power;
        logic signed [POS_W-1:0] position;
        logic                    clear;
        logic [FRAME_W-1:0]      frame;
    } t_window;

    typedef struct packed {
        logic signed [POS_W-1:0] smoothed;
        logic signed [POS_W-1:0] position;
        logic [ACC_W-1:0]        power;
        logic [FRAME_W-1:0]      frame;
    } t_track;

endpackage

[rtl/rtpt_power.sv]
// input register and per-antenna power stage
module rtpt_power import rtpt_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic signed [SAMPLE_W-1:0] i_re,
    input  logic signed [SAMPLE_W-1:0] i_im,
    input  logic signed [POS_W-1:0]    i_tap,
    input  logic                       i_last_ant,
    input  logic                       i_last_tap,
    input  logic                       i_clear,
    input  logic [FRAME_W-1:0]         i_frame,
    output logic                       o_valid,
    input  logic                       i_take,
    output t_sample                    o_sample
);

    logic                       r_s1_valid;
    logic signed [SAMPLE_W-1:0] r_re;
    logic signed [SAMPLE_W-1:0] r_im;
    logic signed [POS_W-1:0]    r_tap;
    logic                       r_last_ant;
    logic                       r_last_tap;
    logic                       r_clear;
    logic [FRAME_W-1:0]         r_frame;
    logic                       r_s2_valid;
    t_sample                    r_s2;

    logic                       w_rdy2;
    logic                       w_rdy1;
    logic signed [31:0]         w_re_x;
    logic signed [31:0]         w_im_x;
    logic signed [31:0]         w_sq_re;
    logic signed [31:0]         w_sq_im;
    t_sample                    n_s2;

    assign w_rdy2  = !r_s2_valid || i_take;
    assign w_rdy1  = !r_s1_valid || w_rdy2;
    assign o_ready = w_rdy1;
    assign o_valid = r_s2_valid;
    assign o_sample = r_s2;

    assign w_re_x  = 32'(r_re);
    assign w_im_x  = 32'(r_im);
    assign w_sq_re = w_re_x * w_re_x;
    assign w_sq_im = w_im_x * w_im_x;

    always_comb begin
        // squares are non-negative, so halving toward zero is a right shift
        n_s2.power    = PWR_W'(w_sq_re[HSQ_W:1]) + PWR_W'(w_sq_im[HSQ_W:1]);
        n_s2.tap      = r_tap;
        n_s2.last_ant = r_last_ant;
        n_s2.last_tap = r_last_tap;
        n_s2.clear    = r_clear;
        n_s2.frame    = r_frame;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_s1_valid <= i_valid;
            end
            if (w_rdy2) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            r_re       <= i_re;
            r_im       <= i_im;
            r_tap      <= i_tap;
            r_last_ant <= i_last_ant;
            r_last_tap <= i_last_tap;
            r_clear    <= i_clear;
            r_frame    <= i_frame;
        end
        if (w_rdy2 && r_s1_valid) begin
            r_s2 <= n_s2;
        end
    end

endmodule

[rtl/rtpt_peak.sv]
// tap power accumulation and strongest-tap search
module rtpt_peak import rtpt_pkg::*; #(
    parameter int HALF_WINDOW  = RTPT_HALF_WINDOW,
    parameter int MAX_ANTENNAS = RTPT_MAX_ANTENNAS
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_sample i_sample,
    output logic    o_take,
    output logic    o_valid,
    input  logic    i_ready,
    output t_window o_window
);

    localparam int AC_W  = $clog2(MAX_ANTENNAS + 1);
    localparam int WIN_W = ($clog2(HALF_WINDOW) + 2 > 10) ? $clog2(HALF_WINDOW) + 2 : 10;
    localparam logic signed [WIN_W-1:0] WIN_HI = WIN_W'(HALF_WINDOW);
    localparam logic signed [WIN_W-1:0] WIN_LO = -WIN_HI;
    localparam logic [AC_W-1:0] ANT_MAX = AC_W'(MAX_ANTENNAS);
    localparam logic [ACC_W-1:0] ACC_SAT = {ACC_W{1'b1}};

    logic [ACC_W-1:0]        r_acc;
    logic [ACC_W-1:0]        r_best_power;
    logic signed [POS_W-1:0] r_best_pos;
    logic [AC_W-1:0]         r_ant;
    logic                    r_valid;
    t_window                 r_win;

    logic                    w_rdy3;
    logic                    w_take;
    logic                    w_use;
    logic [ACC_W:0]          w_sum;
    logic [ACC_W-1:0]        w_acc;
    logic signed [WIN_W-1:0] w_tap_x;
    logic                    w_in_win;
    logic                    w_better;
    logic                    w_close;
    logic [ACC_W-1:0]        w_best_power;
    logic signed [POS_W-1:0] w_best_pos;

    assign w_rdy3 = !r_valid || i_ready;
    assign w_take = i_valid && (!i_sample.last_tap || w_rdy3);
    assign o_take = w_take;
    assign o_valid = r_valid;
    assign o_window = r_win;

    // extra antennas beyond the limit are dropped
    assign w_use = r_ant < ANT_MAX;
    assign w_sum = {1'b0, r_acc} + (ACC_W + 1)'(i_sample.power);

    always_comb begin
        if (!w_use) begin
            w_acc = r_acc;
        end else if (w_sum[ACC_W]) begin
            w_acc = ACC_SAT;
        end else begin
            w_acc = w_sum[ACC_W-1:0];
        end
    end

    assign w_tap_x  = WIN_W'(i_sample.tap);
    assign w_in_win = (w_tap_x >= WIN_LO) && (w_tap_x < WIN_HI);
    assign w_close  = i_sample.last_ant || i_sample.last_tap;
    assign w_better = w_close && w_in_win && (w_acc > r_best_power);

    assign w_best_power = w_better ? w_acc : r_best_power;
    assign w_best_pos   = w_better ? i_sample.tap : r_best_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc        <= '0;
            r_best_power <= '0;
            r_best_pos   <= '0;
            r_ant        <= '0;
            r_valid      <= 1'b0;
        end else begin
            if (w_take) begin
                if (w_close) begin
                    r_acc <= '0;
                    r_ant <= '0;
                end else begin
                    r_acc <= w_acc;
                    r_ant <= w_use ? r_ant + 1'b1 : r_ant;
                end
                if (i_sample.last_tap) begin
                    r_best_power <= '0;
                    r_best_pos   <= '0;
                end else begin
                    r_best_power <= w_best_power;
                    r_best_pos   <= w_best_pos;
                end
            end
            if (w_rdy3) begin
                r_valid <= w_take && i_sample.last_tap;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && i_sample.last_tap) begin
            r_win.power    <= w_best_power;
            r_win.position <= w_best_pos;
            r_win.clear    <= i_sample.clear;
            r_win.frame    <= i_sample.frame;
        end
    end

endmodule

[rtl/rtpt_smooth.sv]
// q15 iir smoothing of the peak position, one update per window
module rtpt_smooth import rtpt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_window           i_window,
    output logic              o_ready,
    input  logic [COEF_W-1:0] i_coef,
    output logic              o_valid,
    input  logic              i_ready,
    output t_track            o_track
);

    localparam int MUL_W = 26;

    logic signed [POS_W-1:0] r_filt;
    logic                    r_valid;
    t_track                  r_track;

    logic                    w_rdy;
    logic                    w_take;
    logic [COEF_W-1:0]       w_ncoef;
    logic signed [MUL_W-1:0] w_old;
    logic signed [MUL_W-1:0] w_new;
    logic signed [MUL_W-1:0] w_c;
    logic signed [MUL_W-1:0] w_nc;
    logic signed [MUL_W-1:0] w_sum;
    logic signed [POS_W-1:0] n_filt;

    assign w_rdy   = !r_valid || i_ready;
    assign w_take  = i_valid && w_rdy;
    assign o_ready = w_rdy;
    assign o_valid = r_valid;
    assign o_track = r_track;

    assign w_ncoef = COEF_FULL - i_coef;
    assign w_old   = MUL_W'(r_filt);
    assign w_new   = MUL_W'(i_window.position);
    assign w_c     = MUL_W'(i_coef);
    assign w_nc    = MUL_W'(w_ncoef);
    assign w_sum   = w_old * w_c + w_new * w_nc;

    // floor division by 2^15 is the arithmetic shift; keep nine bits
    assign n_filt = i_window.clear ? i_window.position : w_sum[COEF_W+POS_W-1:COEF_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filt  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_filt <= n_filt;
            end
            if (w_rdy) begin
                r_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_track.smoothed <= n_filt;
            r_track.position <= i_window.position;
            r_track.power    <= i_window.power;
            r_track.frame    <= i_window.frame;
        end
    end

endmodule

[rtl/rtpt_lock.sv]
// hysteresis check, lock detection and result register
module rtpt_lock import rtpt_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  t_track                  i_track,
    output logic                    o_ready,
    input  logic [HYST_W-1:0]       i_hysteresis,
    input  logic                    i_high_band,
    input  logic                    i_sidelink,
    input  logic                    i_random_access,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [POS_W-1:0] o_correction,
    output logic                    o_for_sidelink,
    output logic signed [POS_W-1:0] o_smoothed,
    output logic signed [POS_W-1:0] o_position,
    output logic [ACC_W-1:0]        o_power,
    output logic                    o_lock_event,
    output logic                    o_start_prach,
    output logic [FRAME_W-1:0]      o_lock_frame
);

    logic [CNT_W-1:0]        r_stable;
    logic                    r_lock_pending;
    logic                    r_valid;
    logic signed [POS_W-1:0] r_correction;
    logic                    r_for_sidelink;
    logic signed [POS_W-1:0] r_smoothed;
    logic signed [POS_W-1:0] r_position;
    logic [ACC_W-1:0]        r_power;
    logic                    r_lock_event;
    logic                    r_start_prach;
    logic [FRAME_W-1:0]      r_lock_frame;

    logic                    w_rdy;
    logic                    w_take;
    logic [POS_W-1:0]        w_mag;
    logic [POS_W-1:0]        w_limit;
    logic [CNT_W-1:0]        n_stable;
    logic                    w_lock;

    assign w_rdy   = !r_valid || i_ready;
    assign w_take  = i_valid && w_rdy;
    assign o_ready = w_rdy;

    assign w_mag   = i_track.smoothed[POS_W-1] ? POS_W'(-i_track.smoothed)
                                               : POS_W'(i_track.smoothed);
    assign w_limit = POS_W'(i_hysteresis) + (i_high_band ? HIGH_BAND_ADD : '0);

    always_comb begin
        if (w_mag < STABLE_LIMIT) begin
            n_stable = (r_stable < STABLE_MAX) ? r_stable + 1'b1 : r_stable;
        end else begin
            n_stable = '0;
        end
    end

    assign w_lock = (n_stable > LOCK_COUNT) && r_lock_pending;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable       <= '0;
            r_lock_pending <= 1'b1;
            r_valid        <= 1'b0;
        end else begin
            if (w_take) begin
                r_stable <= n_stable;
                if (w_lock) begin
                    r_lock_pending <= 1'b0;
                end
            end
            if (w_rdy) begin
                r_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_correction   <= (w_mag > w_limit) ? i_track.smoothed : '0;
            r_for_sidelink <= i_sidelink;
            r_smoothed     <= i_track.smoothed;
            r_position     <= i_track.position;
            r_power        <= i_track.power;
            r_lock_event   <= w_lock;
            r_start_prach  <= w_lock && i_random_access;
            r_lock_frame   <= (w_lock && i_random_access) ? i_track.frame : '0;
        end
    end

    assign o_valid        = r_valid;
    assign o_correction   = r_correction;
    assign o_for_sidelink = r_for_sidelink;
    assign o_smoothed     = r_smoothed;
    assign o_position     = r_position;
    assign o_power        = r_power;
    assign o_lock_event   = r_lock_event;
    assign o_start_prach  = r_start_prach;
    assign o_lock_frame   = r_lock_frame;

endmodule

[rtl/rx_timing_peak_tracker_core.sv]
// top level of the rx timing peak tracker: ports, config registers, pipeline
//
// The slave stream carries channel-estimate words of one cyclic-prefix window,
// tap-major with antennas inner; tlast marks the last tap of the window and
// closes it. Every input word is taken back to back while tready is high, with no
// gap needed between windows.
// One result word leaves on the master stream per window, once the window's
// last word has passed the input, power, peak, iir and result registers. Words
// that do not close a window produce no result.
// The pipeline is input register, power stage, accumulate/peak stage, iir
// stage and lock/result register; the accumulator, the peak search, the iir
// state and the lock counter are the loops, and each closes within its stage.
// When the master side stalls, the result register holds its word and the
// stream side keeps taking words until two more finished windows wait in the
// iir and peak stages and the next closing word plus one more word sit in the
// input and power registers; only then does tready drop.
// Reset clears the accumulator, the peak search, the filter state, the lock
// counter and rearms the one-shot lock event. Registers reset to coefficient
// 0, hysteresis 2 and all mode bits 0. Registers are written over the apb
// port, by the user only while the stream is idle; the block does not check.
module rx_timing_peak_tracker_core import rtpt_pkg::*; #(
    parameter int HALF_WINDOW  = RTPT_HALF_WINDOW,
    parameter int MAX_ANTENNAS = RTPT_MAX_ANTENNAS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // sample_re, sample_im, tap_offset, frame_number, zero pad
    input  logic [55:0] i_s_tdata,
    // last_antenna, clear_filter
    input  logic [1:0]  i_s_tuser,
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // timing_correction, smoothed_position, peak_position, peak_power,
    // lock_frame, zero pad
    output logic [71:0] o_m_tdata,
    // for_sidelink, lock_event, start_prach
    output logic [2:0]  o_m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [COEF_W-1:0] r_filter_coef;
    logic [HYST_W-1:0] r_hysteresis;
    logic              r_high_band;
    logic              r_sidelink;
    logic              r_random_access;

    logic [2:0]        w_index;
    logic              w_write;

    logic              w_pw_valid;
    t_sample           w_sample;
    logic              w_take;
    logic              w_win_valid;
    t_window           w_window;
    logic              w_sm_ready;
    logic              w_tr_valid;
    t_track            w_track;
    logic              w_lk_ready;

    logic signed [POS_W-1:0] w_correction;
    logic                    w_for_sidelink;
    logic signed [POS_W-1:0] w_smoothed;
    logic signed [POS_W-1:0] w_position;
    logic [ACC_W-1:0]        w_power;
    logic                    w_lock_event;
    logic                    w_start_prach;
    logic [FRAME_W-1:0]      w_lock_frame;

    // configuration port
    assign pready  = 1'b1;
    assign w_index = paddr[4:2];
    assign w_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_coef   <= '0;
            r_hysteresis    <= 8'd2;
            r_high_band     <= 1'b0;
            r_sidelink      <= 1'b0;
            r_random_access <= 1'b0;
        end else if (w_write) begin
            case (w_index)
                REG_FILTER_COEF: r_filter_coef   <= pwdata[COEF_W-1:0];
                REG_HYSTERESIS:  r_hysteresis    <= pwdata[HYST_W-1:0];
                REG_HIGH_BAND:   r_high_band     <= pwdata[0];
                REG_SIDELINK:    r_sidelink      <= pwdata[0];
                REG_RANDOM_ACC:  r_random_access <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_index)
            REG_FILTER_COEF: prdata = 32'(r_filter_coef);
            REG_HYSTERESIS:  prdata = 32'(r_hysteresis);
            REG_HIGH_BAND:   prdata = 32'(r_high_band);
            REG_SIDELINK:    prdata = 32'(r_sidelink);
            REG_RANDOM_ACC:  prdata = 32'(r_random_access);
            default:         prdata = '0;
        endcase
    end

    rtpt_power u_power (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_tvalid),
        .o_ready    (o_s_tready),
        .i_re       (i_s_tdata[15:0]),
        .i_im       (i_s_tdata[31:16]),
        .i_tap      (i_s_tdata[40:32]),
        .i_last_ant (i_s_tuser[0]),
        .i_last_tap (i_s_tlast),
        .i_clear    (i_s_tuser[1]),
        .i_frame    (i_s_tdata[48:41]),
        .o_valid    (w_pw_valid),
        .i_take     (w_take),
        .o_sample   (w_sample)
    );

    rtpt_peak #(
        .HALF_WINDOW  (HALF_WINDOW),
        .MAX_ANTENNAS (MAX_ANTENNAS)
    ) u_peak (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_pw_valid),
        .i_sample (w_sample),
        .o_take   (w_take),
        .o_valid  (w_win_valid),
        .i_ready  (w_sm_ready),
        .o_window (w_window)
    );

    rtpt_smooth u_smooth (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_win_valid),
        .i_window (w_window),
        .o_ready  (w_sm_ready),
        .i_coef   (r_filter_coef),
        .o_valid  (w_tr_valid),
        .i_ready  (w_lk_ready),
        .o_track  (w_track)
    );

    rtpt_lock u_lock (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (w_tr_valid),
        .i_track         (w_track),
        .o_ready         (w_lk_ready),
        .i_hysteresis    (r_hysteresis),
        .i_high_band     (r_high_band),
        .i_sidelink      (r_sidelink),
        .i_random_access (r_random_access),
        .o_valid         (o_m_tvalid),
        .i_ready         (i_m_tready),
        .o_correction    (w_correction),
        .o_for_sidelink  (w_for_sidelink),
        .o_smoothed      (w_smoothed),
        .o_position      (w_position),
        .o_power         (w_power),
        .o_lock_event    (w_lock_event),
        .o_start_prach   (w_start_prach),
        .o_lock_frame    (w_lock_frame)
    );

    assign o_m_tdata = {4'd0, w_lock_frame, w_power, w_position, w_smoothed, w_correction};
    assign o_m_tuser = {w_start_prach, w_lock_event, w_for_sidelink};

endmodule
